@@ src/des_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// des_pkg
// Shared types, constants and helpers for the differential evolution core.
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int POP_SIZE = 128;
    localparam int IDX_W    = $clog2(POP_SIZE);

    localparam logic [15:0] SCALE_RST = 16'd19661;   // 0.3 in Q0.16
    localparam logic [16:0] CROSS_RST = 17'd58982;   // 0.9 * 65536

    // Register indexes on the APB port.
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_CROSS = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_EVOLVE = 2'd1,
        CMD_COMMIT = 2'd2
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [63:0]        fit;
    } t_ent;

    typedef struct packed {
        logic             is_load;
        logic             is_evolve;
        logic             bad;
        logic             wr;
        logic             rbank;
        logic             wbank;
        logic             cx;
        logic             cy;
        logic [IDX_W-1:0] idx;
    } t_ctl;

    function automatic logic [IDX_W-1:0] mod_idx(input logic [6:0] v);
        logic [6:0] r;
        r = 7'(v % POP_SIZE);
        return IDX_W'(r);
    endfunction

endpackage
`default_nettype wire

@@ src/des_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// des_ram
// One write port, two registered read ports, read enable shared.
// ----------------------------------------------------------------------------
module des_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [des_pkg::IDX_W-1:0]  i_waddr,
    input  wire des_pkg::t_ent              i_wdata,
    input  wire logic                       i_re,
    input  wire logic [des_pkg::IDX_W-1:0]  i_raddr0,
    input  wire logic [des_pkg::IDX_W-1:0]  i_raddr1,
    output des_pkg::t_ent                   o_rdata0,
    output des_pkg::t_ent                   o_rdata1
);

    des_pkg::t_ent r_mem [des_pkg::POP_SIZE];
    des_pkg::t_ent r_rd0;
    des_pkg::t_ent r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule
`default_nettype wire

@@ src/des_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// des_lane
// One coordinate: b - c, times scale, round and add to a, saturate, select.
// Three register stages.
// ----------------------------------------------------------------------------
module des_lane (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [15:0]        i_scale,
    input  wire logic               i_load,
    input  wire logic               i_cross,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic signed [31:0] i_c,
    input  wire logic signed [31:0] i_tgt,
    input  wire logic signed [31:0] i_load_val,
    output logic signed [31:0]      o_trial
);

    logic signed [32:0] r_d;
    logic signed [31:0] r_a2, r_alt2, r_a3, r_alt3;
    logic               r_use2, r_use3;
    logic signed [49:0] r_p;
    logic signed [31:0] r_trial;

    logic signed [49:0] w_rnd;
    logic signed [49:0] w_q;
    logic signed [49:0] w_sum;
    logic signed [31:0] w_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= {i_b[31], i_b} - {i_c[31], i_c};
            r_a2   <= i_a;
            r_alt2 <= i_load ? i_load_val : i_tgt;
            r_use2 <= i_cross && !i_load;
            r_p    <= 50'(r_d * $signed({1'b0, i_scale}));
            r_a3   <= r_a2;
            r_alt3 <= r_alt2;
            r_use3 <= r_use2;
            r_trial <= r_use3 ? w_sat : r_alt3;
        end
    end

    // round half up, then add base and clamp
    always_comb begin
        w_rnd = r_p + 50'sd32768;
        w_q   = w_rnd >>> 16;
        w_sum = {{18{r_a3[31]}}, r_a3} + w_q;
        if (w_sum > 50'sd2147483647) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_sum < -50'sd2147483648) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign o_trial = r_trial;

endmodule
`default_nettype wire

@@ src/differential_evolution_step_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// differential_evolution_step_core
// Rand/1/bin differential evolution step over a two-bank population.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words (i_valid / o_stall) carry a command: load an individual into
//    the current bank, evolve one target into the next bank, or commit
//    (swap banks). Every word gives exactly one result word (o_valid /
//    i_stall).
//  - o_valid rises once the word is through: the memory read happens at the
//    accepting edge, then difference, multiply, round/saturate, square and
//    sum/select into the output register.
//  - Throughput: one word per cycle while not stalled or held off. Evolves
//    within a generation stream at full rate. An evolve is held off while an
//    earlier load or evolve that writes the bank it reads is still in the 5
//    compute stages, so an evolve right after a load or across a commit waits.
//  - Each bank is two copies of a dual-read RAM so target and all three
//    partners are fetched in the same cycle.
//  - Reset clears control and the register file only; bank contents are
//    undefined until loaded. Bank A is current after reset.
//  - When the receiver stalls a valid result, the whole pipeline freezes; the
//    result is held in the output register and no word is lost or repeated.
//  - Registers (APB): 0x0 mutation scale Q0.16, 0x4 crossover threshold.
// ----------------------------------------------------------------------------
module differential_evolution_step_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [6:0]         i_target,
    input  wire logic [6:0]         i_pick_a,
    input  wire logic [6:0]         i_pick_b,
    input  wire logic [6:0]         i_pick_c,
    input  wire logic [15:0]        i_rand_x,
    input  wire logic [15:0]        i_rand_y,
    input  wire logic               i_force_x,
    input  wire logic               i_force_y,
    input  wire logic signed [31:0] i_load_x,
    input  wire logic signed [31:0] i_load_y,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [6:0]              o_index,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic [63:0]             o_fitness,
    output logic                    o_replaced,
    output logic                    o_bad_picks,
    // config
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = des_pkg::IDX_W;

    // ---------------- config registers ----------------
    logic [15:0] r_scale;
    logic [16:0] r_cross;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= des_pkg::SCALE_RST;
            r_cross <= des_pkg::CROSS_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == des_pkg::REG_SCALE) begin
                r_scale <= pwdata[15:0];
            end else begin
                r_cross <= pwdata[16:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == des_pkg::REG_SCALE) begin
            prdata = {16'd0, r_scale};
        end else begin
            prdata = {15'd0, r_cross};
        end
    end

    // ---------------- pipeline control ----------------
    logic                r_cur;         // current bank
    logic                r_v [1:5];
    des_pkg::t_ctl       r_ctl [1:5];
    logic                r_ov;
    logic                w_en, w_acc, w_hazard;
    des_pkg::t_cmd       w_cmd;
    des_pkg::t_ctl       w_ctl;
    logic [IW-1:0]       w_t, w_a, w_b, w_c;

    assign w_en  = !r_ov || !i_stall;
    assign w_cmd = des_pkg::t_cmd'(i_cmd);
    assign w_t   = des_pkg::mod_idx(i_target);
    assign w_a   = des_pkg::mod_idx(i_pick_a);
    assign w_b   = des_pkg::mod_idx(i_pick_b);
    assign w_c   = des_pkg::mod_idx(i_pick_c);

    // an evolve must not read a bank that an in-flight word still writes
    always_comb begin
        w_hazard = 1'b0;
        for (int s = 1; s <= 5; s++) begin
            if (r_v[s] && r_ctl[s].wr && (r_ctl[s].wbank == r_cur)) begin
                w_hazard = 1'b1;
            end
        end
        w_hazard = w_hazard && (w_cmd == des_pkg::CMD_EVOLVE);
    end

    assign o_stall = !w_en || w_hazard;
    assign w_acc   = i_valid && !o_stall;

    always_comb begin
        w_ctl           = '0;
        w_ctl.idx       = w_t;
        w_ctl.rbank     = r_cur;
        w_ctl.cx        = i_force_x || ({1'b0, i_rand_x} < r_cross);
        w_ctl.cy        = i_force_y || ({1'b0, i_rand_y} < r_cross);
        w_ctl.bad       = (w_a == w_t) || (w_b == w_t) || (w_c == w_t)
                       || (w_a == w_b) || (w_a == w_c) || (w_b == w_c);
        case (w_cmd)
            des_pkg::CMD_LOAD: begin
                w_ctl.is_load = 1'b1;
                w_ctl.wr      = 1'b1;
                w_ctl.wbank   = r_cur;
            end
            des_pkg::CMD_EVOLVE: begin
                w_ctl.is_evolve = 1'b1;
                w_ctl.wr        = 1'b1;
                w_ctl.wbank     = !r_cur;
            end
            default: begin
                w_ctl.wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 1'b0;
            r_ov  <= 1'b0;
            for (int s = 1; s <= 5; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (w_en) begin
            if (w_acc && (w_cmd == des_pkg::CMD_COMMIT)) begin
                r_cur <= !r_cur;
            end
            r_v[1] <= w_acc;
            for (int s = 2; s <= 5; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl[1] <= w_ctl;
            for (int s = 2; s <= 5; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // ---------------- banks: two copies each, four reads a cycle ----------
    logic          w_we;
    logic          w_we_a, w_we_b;
    des_pkg::t_ent w_wdata;
    des_pkg::t_ent w_a0, w_a1, w_a2, w_a3, w_b0, w_b1, w_b2, w_b3;

    assign w_we   = w_en && r_v[5] && r_ctl[5].wr;
    assign w_we_a = w_we && !r_ctl[5].wbank;
    assign w_we_b = w_we &&  r_ctl[5].wbank;

    des_ram u_ram_a0 (.i_clk(i_clk), .i_we(w_we_a), .i_waddr(r_ctl[5].idx),
        .i_wdata(w_wdata), .i_re(w_acc), .i_raddr0(w_t), .i_raddr1(w_a),
        .o_rdata0(w_a0), .o_rdata1(w_a1));
    des_ram u_ram_a1 (.i_clk(i_clk), .i_we(w_we_a), .i_waddr(r_ctl[5].idx),
        .i_wdata(w_wdata), .i_re(w_acc), .i_raddr0(w_b), .i_raddr1(w_c),
        .o_rdata0(w_a2), .o_rdata1(w_a3));
    des_ram u_ram_b0 (.i_clk(i_clk), .i_we(w_we_b), .i_waddr(r_ctl[5].idx),
        .i_wdata(w_wdata), .i_re(w_acc), .i_raddr0(w_t), .i_raddr1(w_a),
        .o_rdata0(w_b0), .o_rdata1(w_b1));
    des_ram u_ram_b1 (.i_clk(i_clk), .i_we(w_we_b), .i_waddr(r_ctl[5].idx),
        .i_wdata(w_wdata), .i_re(w_acc), .i_raddr0(w_b), .i_raddr1(w_c),
        .o_rdata0(w_b2), .o_rdata1(w_b3));

    // stage 1: pick the bank that was current at acceptance
    des_pkg::t_ent w_tgt, w_pa, w_pb, w_pc;
    assign w_tgt = r_ctl[1].rbank ? w_b0 : w_a0;
    assign w_pa  = r_ctl[1].rbank ? w_b1 : w_a1;
    assign w_pb  = r_ctl[1].rbank ? w_b2 : w_a2;
    assign w_pc  = r_ctl[1].rbank ? w_b3 : w_a3;

    logic signed [31:0] r_ldx1, r_ldy1;
    des_pkg::t_ent      r_tgt [2:5];

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ldx1 <= i_load_x;
            r_ldy1 <= i_load_y;
        end
        if (w_en) begin
            r_tgt[2] <= w_tgt;
            for (int s = 3; s <= 5; s++) begin
                r_tgt[s] <= r_tgt[s-1];
            end
        end
    end

    // stages 2..4: mutation lanes
    logic signed [31:0] w_trx, w_try;

    des_lane u_lane_x (.i_clk(i_clk), .i_en(w_en), .i_scale(r_scale),
        .i_load(r_ctl[1].is_load), .i_cross(r_ctl[1].cx),
        .i_a(w_pa.x), .i_b(w_pb.x), .i_c(w_pc.x), .i_tgt(w_tgt.x),
        .i_load_val(r_ldx1), .o_trial(w_trx));
    des_lane u_lane_y (.i_clk(i_clk), .i_en(w_en), .i_scale(r_scale),
        .i_load(r_ctl[1].is_load), .i_cross(r_ctl[1].cy),
        .i_a(w_pa.y), .i_b(w_pb.y), .i_c(w_pc.y), .i_tgt(w_tgt.y),
        .i_load_val(r_ldy1), .o_trial(w_try));

    // stage 4 -> 5: squares of magnitudes
    logic [31:0]        w_ax, w_ay;
    logic [63:0]        r_sqx, r_sqy;
    logic signed [31:0] r_trx5, r_try5;

    assign w_ax = w_trx[31] ? 32'(-w_trx) : 32'(w_trx);
    assign w_ay = w_try[31] ? 32'(-w_try) : 32'(w_try);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx  <= w_ax * w_ax;
            r_sqy  <= w_ay * w_ay;
            r_trx5 <= w_trx;
            r_try5 <= w_try;
        end
    end

    // stage 5: score, select survivor
    logic [64:0]   w_sum;
    des_pkg::t_ent w_trial;
    des_pkg::t_ent w_res;
    logic          w_rep, w_bad;
    logic [6:0]    w_idx;

    assign w_sum       = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_trial.x   = r_trx5;
    assign w_trial.y   = r_try5;
    assign w_trial.fit = w_sum[65-1:2] == 63'd0 ? 64'd0 : {1'b0, w_sum[64:2]};

    always_comb begin
        w_res = '0;
        w_rep = 1'b0;
        w_bad = 1'b0;
        w_idx = 7'(r_ctl[5].idx);
        if (r_ctl[5].is_load) begin
            w_res = w_trial;
        end else if (r_ctl[5].is_evolve) begin
            if (r_ctl[5].bad) begin
                w_res = r_tgt[5];
                w_bad = 1'b1;
            end else if (w_trial.fit < r_tgt[5].fit) begin
                w_res = w_trial;
                w_rep = 1'b1;
            end else begin
                w_res = r_tgt[5];
            end
        end else begin
            w_idx = 7'd0;
        end
    end

    assign w_wdata = w_res;

    logic [6:0]         r_oidx;
    des_pkg::t_ent      r_ores;
    logic               r_orep, r_obad;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oidx <= w_idx;
            r_ores <= w_res;
            r_orep <= w_rep;
            r_obad <= w_bad;
        end
    end

    assign o_valid     = r_ov;
    assign o_index     = r_oidx;
    assign o_out_x     = r_ores.x;
    assign o_out_y     = r_ores.y;
    assign o_fitness   = r_ores.fit;
    assign o_replaced  = r_orep;
    assign o_bad_picks = r_obad;

    // ---------------- assertions ----------------
    a_rep_bad_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_replaced && o_bad_picks))
        else $error("replaced and bad_picks both set");

    a_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_cmd == des_pkg::CMD_EVOLVE)) |=>
        !(w_we && r_v[1] && (r_ctl[5].wbank == r_ctl[1].rbank)))
        else $error("bank written while an evolve reads it");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(r_ores) && $stable(o_index)))
        else $error("result word changed while stalled");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load, evolve and commit words with random gaps and output stalls,
// predicts every result word from a shadow two-bank population and checks
// the results field by field, in order. Random loads fill both banks first,
// then the directed table comes and the random part follows.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT = 400000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0]         index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [63:0]        fit;
        logic               replaced;
        logic               bad;
    } t_res;

    typedef struct {
        logic [1:0]         cmd;
        logic [6:0]         target;
        logic [6:0]         pa;
        logic [6:0]         pb;
        logic [6:0]         pc;
        logic [15:0]        rx;
        logic [15:0]        ry;
        logic               fx;
        logic               fy;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
    } t_word;

    // directed row: word plus an optional typed-in expectation
    typedef struct {
        t_word word;
        bit    typed;
        t_res  res;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall;
    logic [1:0] i_cmd;
    logic [6:0] i_target, i_pick_a, i_pick_b, i_pick_c;
    logic [15:0] i_rand_x, i_rand_y;
    logic i_force_x, i_force_y;
    logic signed [31:0] i_load_x, i_load_y;
    logic o_valid, i_stall;
    logic [6:0] o_index;
    logic signed [31:0] o_out_x, o_out_y;
    logic [63:0] o_fitness;
    logic o_replaced, o_bad_picks;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    differential_evolution_step_core uut (.*);

    // shadow population
    des_pkg::t_ent bank [2][des_pkg::POP_SIZE];
    bit            cur_bank;
    logic [15:0]   scale;
    logic [16:0]   cross_thr;

    t_res        results_due[$];
    int          errors;
    int          cycles;
    bit          hold_off;
    bit          stim_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [63:0] squares(logic signed [31:0] x, logic signed [31:0] y);
        logic [127:0] s;
        s = 128'($signed(x) * $signed(x)) + 128'($signed(y) * $signed(y));
        return 64'(s >> 2);
    endfunction

    // a + scale*(b-c), rounded half up then saturated to 32 bits
    function automatic logic signed [31:0] mutate(logic signed [31:0] a,
            logic signed [31:0] b, logic signed [31:0] c);
        logic signed [63:0] p;
        logic signed [63:0] q;
        p = (64'(b) - 64'(c)) * $signed({48'd0, scale});
        q = (p + 64'sd32768) >>> 16;
        q = q + 64'(a);
        if (q > 64'sd2147483647) return 32'sh7fffffff;
        if (q < -64'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic t_res predict_step(t_word w);
        t_res r;
        des_pkg::t_ent tgt, trial, ea, eb, ec;
        logic [6:0] t, a, b, c;
        bit cx, cy;
        r = '{default: '0};
        t = 7'(w.target % des_pkg::POP_SIZE);
        a = 7'(w.pa % des_pkg::POP_SIZE);
        b = 7'(w.pb % des_pkg::POP_SIZE);
        c = 7'(w.pc % des_pkg::POP_SIZE);
        case (w.cmd)
            des_pkg::CMD_LOAD: begin
                bank[cur_bank][t] = '{w.lx, w.ly, squares(w.lx, w.ly)};
                r = '{t, w.lx, w.ly, bank[cur_bank][t].fit, 1'b0, 1'b0};
            end
            des_pkg::CMD_EVOLVE: begin
                tgt = bank[cur_bank][t];
                if (a == t || b == t || c == t || a == b || a == c || b == c) begin
                    bank[!cur_bank][t] = tgt;
                    r = '{t, tgt.x, tgt.y, tgt.fit, 1'b0, 1'b1};
                end else begin
                    ea = bank[cur_bank][a];
                    eb = bank[cur_bank][b];
                    ec = bank[cur_bank][c];
                    cx = w.fx || ({1'b0, w.rx} < cross_thr);
                    cy = w.fy || ({1'b0, w.ry} < cross_thr);
                    trial.x = cx ? mutate(ea.x, eb.x, ec.x) : tgt.x;
                    trial.y = cy ? mutate(ea.y, eb.y, ec.y) : tgt.y;
                    trial.fit = squares(trial.x, trial.y);
                    if (trial.fit < tgt.fit) begin
                        bank[!cur_bank][t] = trial;
                        r = '{t, trial.x, trial.y, trial.fit, 1'b1, 1'b0};
                    end else begin
                        bank[!cur_bank][t] = tgt;
                        r = '{t, tgt.x, tgt.y, tgt.fit, 1'b0, 1'b0};
                    end
                end
            end
            des_pkg::CMD_COMMIT: cur_bank = !cur_bank;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // output side: random stall, with one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            n = $urandom_range(0, 9);
            i_stall <= (n < 3) && !stim_done;
        end
    end

    // check accepted results
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $display("unexpected result word at cycle %0d", cycles);
                errors++;
            end else begin
                e = results_due.pop_front();
                if (o_index !== e.index) report("index", 64'(o_index), 64'(e.index));
                if (o_out_x !== e.x) report("out_x", 64'(o_out_x), 64'(e.x));
                if (o_out_y !== e.y) report("out_y", 64'(o_out_y), 64'(e.y));
                if (o_fitness !== e.fit) report("fitness", o_fitness, e.fit);
                if (o_replaced !== e.replaced)
                    report("replaced", 64'(o_replaced), 64'(e.replaced));
                if (o_bad_picks !== e.bad)
                    report("bad_picks", 64'(o_bad_picks), 64'(e.bad));
            end
        end
    end

    task automatic send(t_word w);
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= w.cmd;
        i_target <= w.target;
        i_pick_a <= w.pa;
        i_pick_b <= w.pb;
        i_pick_c <= w.pc;
        i_rand_x <= w.rx;
        i_rand_y <= w.ry;
        i_force_x <= w.fx;
        i_force_y <= w.fy;
        i_load_x <= w.lx;
        i_load_y <= w.ly;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic reg_write(logic reg_idx, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        if (reg_idx == des_pkg::REG_SCALE) scale = v[15:0];
        else cross_thr = v[16:0];
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word rand_word(int kind);
        t_word w;
        w.cmd = kind[1:0];
        w.target = 7'($urandom); w.pa = 7'($urandom);
        w.pb = 7'($urandom); w.pc = 7'($urandom);
        if ($urandom_range(0, 7) == 0) w.pb = w.pa;
        w.rx = 16'($urandom); w.ry = 16'($urandom);
        w.fx = 1'($urandom); w.fy = 1'($urandom);
        w.lx = rand_coord(); w.ly = rand_coord();
        return w;
    endfunction

    function automatic t_word mk(int cmd, int t, int a, int b, int c, int fx, int fy,
            logic signed [31:0] lx, logic signed [31:0] ly);
        return '{2'(cmd), 7'(t), 7'(a), 7'(b), 7'(c), 16'hffff, 16'h0000,
                 1'(fx), 1'(fy), lx, ly};
    endfunction

    initial begin
        t_row       rows[$];
        t_res       r, zero_res;
        logic [1:0] kind;
        int         n;
        errors = 0; stim_done = 0; hold_off = 0;
        cur_bank = 0; scale = des_pkg::SCALE_RST; cross_thr = des_pkg::CROSS_RST;
        zero_res = '{default: '0};
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_cmd = des_pkg::CMD_LOAD;
        i_target = '0; i_pick_a = '0; i_pick_b = '0; i_pick_c = '0;
        i_rand_x = '0; i_rand_y = '0; i_force_x = 0; i_force_y = 0;
        i_load_x = '0; i_load_y = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill shadow bank 0 only; these loads are not sent to the core
        for (int i = 0; i < des_pkg::POP_SIZE; i++) begin
            r = predict_step(mk(des_pkg::CMD_LOAD, i, 0, 0, 0, 0, 0, rand_coord(),
                                rand_coord()));
        end
        // reset the shadow bank select; the loads sent below overwrite these entries
        cur_bank = 0;
        rows.push_back('{mk(des_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 32'sh7fffffff,
                            32'sh80000000), 1'b1,
                         '{7'd0, 32'sh7fffffff, 32'sh80000000,
                           64'h1fff_ffff_c000_0000, 1'b0, 1'b0}});
        rows.push_back('{mk(des_pkg::CMD_LOAD, 127, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{7'd127, 32'sd0, 32'sd0, 64'd0, 1'b0, 1'b0}});
        rows.push_back('{mk(des_pkg::CMD_LOAD, 1, 0, 0, 0, 0, 0, 32'sh00100000, 0),
                         1'b1, '{7'd1, 32'sh00100000, 32'sd0,
                                 64'h0000_0040_0000_0000, 1'b0, 1'b0}});
        rows.push_back('{mk(des_pkg::CMD_EVOLVE, 1, 1, 2, 3, 1, 1, 0, 0), 1'b0, zero_res});
        rows.push_back('{mk(des_pkg::CMD_EVOLVE, 2, 5, 5, 6, 1, 1, 0, 0), 1'b0, zero_res});
        rows.push_back('{mk(des_pkg::CMD_EVOLVE, 3, 4, 5, 6, 1, 1, 0, 0), 1'b0, zero_res});
        rows.push_back('{mk(des_pkg::CMD_EVOLVE, 4, 0, 127, 1, 1, 0, 0, 0), 1'b0, zero_res});
        rows.push_back('{mk(des_pkg::CMD_EVOLVE, 5, 127, 0, 1, 0, 1, 0, 0), 1'b0, zero_res});
        rows.push_back('{mk(des_pkg::CMD_EVOLVE, 6, 7, 8, 9, 0, 0, 0, 0), 1'b0, zero_res});
        rows.push_back('{mk(des_pkg::CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_res});
        rows.push_back('{mk(CMD_UNUSED, 9, 1, 2, 3, 1, 1, -1, -1), 1'b1, zero_res});
        rows.push_back('{mk(des_pkg::CMD_COMMIT, 127, 127, 127, 127, 1, 1, -1, -1),
                         1'b1, zero_res});

        // every entry of both banks written before any evolve reads them
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < des_pkg::POP_SIZE; i++) begin
                t_word w;
                w = rand_word(des_pkg::CMD_LOAD);
                w.target = i[6:0];
                results_due.push_back(predict_step(w));
                send(w);
            end
            results_due.push_back(predict_step(mk(des_pkg::CMD_COMMIT, 0, 0, 0, 0, 0, 0,
                                                  0, 0)));
            send(mk(des_pkg::CMD_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0));
        end
        foreach (rows[k]) begin
            r = predict_step(rows[k].word);
            if (rows[k].typed && r != rows[k].res)
                $display("directed row %0d typed value disagrees", k);
            results_due.push_back(rows[k].typed ? rows[k].res : r);
            send(rows[k].word);
        end
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    reg_write(des_pkg::REG_SCALE, 32'd0);
                    reg_write(des_pkg::REG_CROSS, 32'd0);
                end
                1: begin
                    reg_write(des_pkg::REG_SCALE, 32'd65535);
                    reg_write(des_pkg::REG_CROSS, 32'd65536);
                end
                2: begin
                    reg_write(des_pkg::REG_SCALE, 32'd32768);
                    reg_write(des_pkg::REG_CROSS, 32'd65535);
                end
                default: begin
                    reg_write(des_pkg::REG_SCALE, $urandom_range(0, 65535));
                    reg_write(des_pkg::REG_CROSS, $urandom_range(0, 65536));
                end
            endcase
            if (ph == 3) hold_off = 1;
            for (int i = 0; i < 175; i++) begin
                n = $urandom_range(0, 99);
                kind = (n < 15) ? des_pkg::CMD_LOAD : (n < 92) ? des_pkg::CMD_EVOLVE :
                       (n < 98) ? des_pkg::CMD_COMMIT : CMD_UNUSED;
                begin
                    t_word w;
                    w = rand_word(kind);
                    results_due.push_back(predict_step(w));
                    send(w);
                end
            end
            drain();
        end

        stim_done = 1;
        i_valid <= 1'b0;
        n = 0;
        while (results_due.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/des_pkg.sv
src/des_ram.sv
src/des_lane.sv
src/differential_evolution_step_core.sv
test/testbench.sv
